### src/erfq_pkg.sv
// ----------------------------------------------------------------------------
// erfq_pkg
// Types and constants shared by the Ethernet receive frame qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package erfq_pkg;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT   = 2'd0,
    VERDICT_RUNT     = 2'd1,
    VERDICT_DISABLED = 2'd2,
    VERDICT_FILTERED = 2'd3
  } verdict_t;

  localparam logic [2:0] REG_STATION_ADDR = 3'd0;
  localparam logic [2:0] REG_MCAST_FILTER = 3'd1;
  localparam logic [2:0] REG_PROMISCUOUS  = 3'd2;
  localparam logic [2:0] REG_RX_ENABLE    = 3'd3;
  localparam logic [2:0] REG_FCS_ENABLE   = 3'd4;

  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_PRESET  = 32'hFFFFFFFF;
  localparam logic [31:0] CRC_RESIDUE = 32'h2144DF1C;
  localparam logic [11:0] COUNT_MAX   = 12'hFFF;
  localparam logic [11:0] ADDR_BYTES  = 12'd6;
  localparam logic [47:0] BCAST_ADDR  = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [11:0] length;
    logic [47:0] dest;
    logic [5:0]  hash;
    logic [31:0] crc;
  } frame_sum_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### src/ethernet_rx_frame_qualifier.sv
// ----------------------------------------------------------------------------
// ethernet_rx_frame_qualifier
// Ethernet receive frame qualifier with address filter and CRC-32 check.
// ----------------------------------------------------------------------------
// The in_ channel carries one received frame byte per word, destination
// address first, with in_tlast on the final byte. One byte is accepted in
// every cycle while in_tready is high; the bytewise CRC update and byte
// count sit between the input handshake and the frame state registers.
// For each final byte one word leaves on the out_ channel with the verdict,
// the CRC error flag and the saturated frame length. The final byte's frame
// is first held in the frame summary register, and the verdict logic then
// feeds the output register, from which the result word is taken.
// Non-final bytes produce no output word.
// When the receiver stalls, the output register holds its word and the
// summary register takes the next frame end; input is held off only when both
// are full, so a new frame streams in while a verdict waits.
// Reset clears the frame state, the pipeline and the configuration registers
// (FCS checking comes up enabled). Configuration is written through the APB
// port at byte address 8*index.
// ----------------------------------------------------------------------------
`default_nettype none

module ethernet_rx_frame_qualifier
  import erfq_pkg::*;
#(
  parameter int MIN_FRAME_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] data_byte
  input  wire logic        in_tlast,     // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,    // [1:0] verdict, [2] crc_error,
                                         // [14:3] frame_length, [15] zero
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [11:0] MIN_LEN = 12'(MIN_FRAME_BYTES);

  logic [47:0] station_r;
  logic [63:0] mcast_r;
  logic        promisc_r;
  logic        rx_en_r;
  logic        fcs_en_r;

  logic        cfg_wr;
  logic [2:0]  reg_idx;

  logic [31:0] crc_r;
  logic [5:0]  hash_r;
  logic [11:0] count_r;
  logic [47:0] dest_r;

  logic [31:0] crc_nxt;
  logic [5:0]  hash_nxt;
  logic [11:0] count_nxt;
  logic [47:0] dest_nxt;

  logic        in_acc;
  logic        s1_valid_r;
  frame_sum_t  sum_r;
  logic        s1_adv;

  logic        out_valid_r;
  verdict_t    out_verdict_r;
  logic        out_err_r;
  logic [11:0] out_len_r;

  verdict_t    verdict_nxt;
  logic        err_nxt;
  logic        addr_pass;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= '0;
      mcast_r   <= '0;
      promisc_r <= 1'b0;
      rx_en_r   <= 1'b0;
      fcs_en_r  <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_STATION_ADDR: station_r <= cfg_pwdata[47:0];
        REG_MCAST_FILTER: mcast_r   <= cfg_pwdata;
        REG_PROMISCUOUS:  promisc_r <= cfg_pwdata[0];
        REG_RX_ENABLE:    rx_en_r   <= cfg_pwdata[0];
        REG_FCS_ENABLE:   fcs_en_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STATION_ADDR: cfg_prdata = {16'd0, station_r};
      REG_MCAST_FILTER: cfg_prdata = mcast_r;
      REG_PROMISCUOUS:  cfg_prdata = {63'd0, promisc_r};
      REG_RX_ENABLE:    cfg_prdata = {63'd0, rx_en_r};
      REG_FCS_ENABLE:   cfg_prdata = {63'd0, fcs_en_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // Per-byte frame state update.
  assign in_acc = in_tvalid & in_tready;

  always_comb begin
    crc_nxt   = crc_byte(crc_r, in_tdata);
    count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + 12'd1;
    dest_nxt  = dest_r;
    if (count_r < ADDR_BYTES) begin
      dest_nxt[{count_r[2:0], 3'b000} +: 8] = in_tdata;
    end
    hash_nxt  = (count_nxt == ADDR_BYTES) ? ~crc_nxt[31:26] : hash_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_PRESET;
      hash_r  <= '0;
      count_r <= '0;
      dest_r  <= '0;
    end else if (in_acc) begin
      if (in_tlast) begin
        crc_r   <= CRC_PRESET;
        hash_r  <= '0;
        count_r <= '0;
        dest_r  <= '0;
      end else begin
        crc_r   <= crc_nxt;
        hash_r  <= hash_nxt;
        count_r <= count_nxt;
        dest_r  <= dest_nxt;
      end
    end
  end

  // Frame summary register.
  assign s1_adv    = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc && in_tlast) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      sum_r.length <= count_nxt;
      sum_r.dest   <= dest_nxt;
      sum_r.hash   <= hash_nxt;
      sum_r.crc    <= crc_nxt;
    end
  end

  // Verdict.
  always_comb begin
    if (promisc_r) begin
      addr_pass = 1'b1;
    end else if (sum_r.dest[0]) begin
      addr_pass = (sum_r.dest == BCAST_ADDR) | mcast_r[~sum_r.hash];
    end else begin
      addr_pass = (sum_r.dest == station_r);
    end

    err_nxt = 1'b0;
    if (sum_r.length < MIN_LEN) begin
      verdict_nxt = VERDICT_RUNT;
    end else if (!rx_en_r) begin
      verdict_nxt = VERDICT_DISABLED;
    end else if (!addr_pass) begin
      verdict_nxt = VERDICT_FILTERED;
    end else begin
      verdict_nxt = VERDICT_ACCEPT;
      err_nxt     = fcs_en_r & (~sum_r.crc != CRC_RESIDUE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_verdict_r <= verdict_nxt;
      out_err_r     <= err_nxt;
      out_len_r     <= sum_r.length;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_len_r, out_err_r, out_verdict_r};

  // Assertions.
  a_err_only_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_err_r || out_verdict_r == VERDICT_ACCEPT))
    else $error("crc_error set on a frame that was not accepted");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (count_r == 12'd0 && crc_r == CRC_PRESET))
    else $error("frame state not cleared after the final byte");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input held off while the output register is empty");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_len_r != 12'd0))
    else $error("result with zero frame length");

endmodule

`default_nettype wire
